// ===== rtl/core/sha_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 hasher.
// Used by sha_ctrl, sha_datapath and sha256_hash; depends on nothing.
package sha_pkg;

	// Input request: one optional message byte and an end-of-message flag
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} in_item_t;

	// Output request: one digest word
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// Source of a padding byte
	typedef enum logic [1:0] {
		PAD_MARK,
		PAD_ZERO,
		PAD_LEN
	} pad_kind_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic      take_in;
		logic      pad_push;
		pad_kind_t pad_kind;
		logic      round_load;
		logic      round_en;
		logic [5:0] round_idx;
		logic      fold;
		logic      emit_load;
		logic [2:0] emit_idx;
		logic      restart;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [5:0] fill;
		logic       out_free;
	} sts_t;

	localparam logic [7:0] PadMarkByte = 8'h80;
	localparam logic [5:0] FillLast    = 6'd63;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
			input logic [31:0] g);
		choose = (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] major(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		major = (a & b) ^ (a & c) ^ (b & c);
	endfunction

	// Initial hash value, word by word
	function automatic logic [31:0] iv_word(input logic [2:0] idx);
		case (idx)
			3'd0: iv_word = 32'h6a09e667;
			3'd1: iv_word = 32'hbb67ae85;
			3'd2: iv_word = 32'h3c6ef372;
			3'd3: iv_word = 32'ha54ff53a;
			3'd4: iv_word = 32'h510e527f;
			3'd5: iv_word = 32'h9b05688c;
			3'd6: iv_word = 32'h1f83d9ab;
			default: iv_word = 32'h5be0cd19;
		endcase
	endfunction

	// Round constants
	function automatic logic [31:0] round_k(input logic [5:0] idx);
		case (idx)
			6'd0:  round_k = 32'h428a2f98;
			6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;
			6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;
			6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;
			6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;
			6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;
			6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;
			6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;
			6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;
			6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;
			6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;
			6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;
			6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;
			6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;
			6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;
			6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;
			6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;
			6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;
			6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;
			6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;
			6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;
			6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;
			6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;
			6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;
			6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;
			6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;
			6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;
			6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;
			6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;
			6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;
			6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;
			6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;
			default: round_k = 32'hc67178f2;
		endcase
	endfunction

endpackage

// ===== rtl/core/sha_ctrl.sv =====
// Sequencer for the SHA-256 hasher: byte intake, padding, rounds, fold, digest.
// Depends on sha_pkg; drives the command struct consumed by sha_datapath.
module sha_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          has_byte,
	input  logic          last,
	input  sha_pkg::sts_t sts,
	output sha_pkg::cmd_t cmd
);
	import sha_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_ROUND,
		S_FOLD,
		S_EMIT
	} state_t;

	state_t     state_q;
	logic [5:0] rnd_q;
	logic [2:0] emit_q;
	logic       pad_first_q;
	logic       two_blk_q;
	logic       pend_pad_q;
	logic       final_q;
	logic [5:0] fill_next;
	logic       fill_hi;
	pad_kind_t  pad_kind;

	assign fill_next = sts.fill + 6'd1;
	assign fill_hi   = (sts.fill[5:3] == 3'b111);
	assign in_ready  = (state_q == S_IDLE);

	// Pick the next padding byte: marker first, length only in the final block
	always_comb begin
		if (pad_first_q) begin
			pad_kind = PAD_MARK;
		end else if (fill_hi && !two_blk_q) begin
			pad_kind = PAD_LEN;
		end else begin
			pad_kind = PAD_ZERO;
		end
	end

	// Decode commands from the current state
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_in    = has_byte;
					cmd.round_load = has_byte && (sts.fill == FillLast);
				end
			end
			S_PAD: begin
				cmd.pad_push   = 1'b1;
				cmd.pad_kind   = pad_kind;
				cmd.round_load = (sts.fill == FillLast);
			end
			S_ROUND: begin
				cmd.round_en  = 1'b1;
				cmd.round_idx = rnd_q;
			end
			S_FOLD: begin
				cmd.fold = 1'b1;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_load = 1'b1;
					cmd.emit_idx  = emit_q;
					cmd.restart   = (emit_q == 3'd7);
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Hold state and sequencing flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rnd_q       <= '0;
			emit_q      <= '0;
			pad_first_q <= 1'b0;
			two_blk_q   <= 1'b0;
			pend_pad_q  <= 1'b0;
			final_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (has_byte && (sts.fill == FillLast)) begin
							state_q     <= S_ROUND;
							rnd_q       <= '0;
							final_q     <= 1'b0;
							pend_pad_q  <= last;
							pad_first_q <= last;
							two_blk_q   <= 1'b0;
						end else if (last) begin
							state_q     <= S_PAD;
							pad_first_q <= 1'b1;
							two_blk_q   <= has_byte ? (fill_next[5:3] == 3'b111) : fill_hi;
						end
					end
				end
				S_PAD: begin
					pad_first_q <= 1'b0;
					if (sts.fill == FillLast) begin
						state_q    <= S_ROUND;
						rnd_q      <= '0;
						final_q    <= (pad_kind == PAD_LEN);
						two_blk_q  <= 1'b0;
						pend_pad_q <= 1'b1;
					end
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					if (final_q) begin
						state_q <= S_EMIT;
						emit_q  <= '0;
					end else if (pend_pad_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (sts.out_free) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) begin
							state_q    <= S_IDLE;
							final_q    <= 1'b0;
							pend_pad_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/sha_datapath.sv =====
// Datapath of the SHA-256 hasher: block shift register, schedule, round unit,
// chaining value, byte count and digest output register. Depends on sha_pkg.
module sha_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        data_byte,
	input  sha_pkg::cmd_t     cmd,
	output sha_pkg::sts_t     sts,
	output logic              out_valid,
	input  logic              out_ready,
	output sha_pkg::out_item_t out_data
);
	import sha_pkg::*;

	logic [511:0] blk_q;
	logic [5:0]   fill_q;
	logic [60:0]  count_q;
	logic [31:0]  chain_q [8];
	logic [31:0]  work_q [8];
	logic         out_valid_q;
	out_item_t    out_q;

	logic [63:0]  len_bits;
	logic [7:0]   push_byte;
	logic         push;
	logic [31:0]  w0;
	logic [31:0]  w1;
	logic [31:0]  w9;
	logic [31:0]  w14;
	logic [31:0]  w_new;
	logic [31:0]  t1;
	logic [31:0]  t2;

	assign len_bits = {count_q, 3'b000};
	assign push     = cmd.take_in || cmd.pad_push;

	// Choose the byte entering the block
	always_comb begin
		if (cmd.take_in) begin
			push_byte = data_byte;
		end else begin
			case (cmd.pad_kind)
				PAD_MARK: push_byte = PadMarkByte;
				PAD_LEN:  push_byte = len_bits[{~fill_q[2:0], 3'b000} +: 8];
				default:  push_byte = 8'h00;
			endcase
		end
	end

	// Schedule taps: the oldest word of the window is the current one
	assign w0    = blk_q[511:480];
	assign w1    = blk_q[479:448];
	assign w9    = blk_q[223:192];
	assign w14   = blk_q[63:32];
	assign w_new = ssig1(w14) + w9 + ssig0(w1) + w0;

	// Round arithmetic
	assign t1 = work_q[7] + bsig1(work_q[4]) + choose(work_q[4], work_q[5], work_q[6])
		+ round_k(cmd.round_idx) + w0;
	assign t2 = bsig0(work_q[0]) + major(work_q[0], work_q[1], work_q[2]);

	// Shift bytes in, then slide the schedule window during rounds
	always_ff @(posedge clk) begin
		if (push) begin
			blk_q <= {blk_q[503:0], push_byte};
		end else if (cmd.round_en) begin
			blk_q <= {blk_q[479:0], w_new};
		end
	end

	// Advance the working variables
	always_ff @(posedge clk) begin
		if (cmd.round_load) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= chain_q[i];
			end
		end else if (cmd.round_en) begin
			work_q[0] <= t1 + t2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + t1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
		end
	end

	// Hold fill position, byte count and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= iv_word(3'(i));
			end
		end else begin
			if (push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.restart) begin
				count_q <= '0;
			end else if (cmd.take_in) begin
				count_q <= count_q + 61'd1;
			end
			if (cmd.restart) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= iv_word(3'(i));
				end
			end else if (cmd.fold) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + work_q[i];
				end
			end
		end
	end

	// Digest output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_q.digest_word <= chain_q[cmd.emit_idx];
			out_q.word_index  <= cmd.emit_idx;
			out_q.last_word   <= (cmd.emit_idx == 3'd7);
		end
	end

	assign sts.fill     = fill_q;
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule

// ===== rtl/core/sha256_hash.sv =====
// SHA-256 byte-stream hasher, top level.
// Input channel (in_valid/in_ready/in_data): one request per message byte, with
// has_byte marking a real byte and last closing the message. A request with
// last and no byte ends the message on the bytes already taken.
// Output channel (out_valid/out_ready/out_data): after a last request, eight
// digest words, index 0 (H0) first, last_word set on index 7.
// Timing: a byte request is taken in any cycle in which in_ready is high. The
// 64th byte of a block starts a compression of 64 rounds and then a fold; the
// round unit does one round a cycle. On last, padding shifts in one byte a
// cycle up to the block end (one or two blocks, each followed by a
// compression), then the eight words are loaded into the output register one
// a cycle as the receiver takes them.
// A stalled receiver holds the current word and the block waits in the digest
// phase; once the eighth word is loaded, in_ready rises and the next message
// may start while that word is still waiting.
// Reset: the chaining value returns to the initial hash value, the byte count
// to zero, and no output is pending.
module sha256_hash (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sha_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sha_pkg::out_item_t  out_data
);
	import sha_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.has_byte (in_data.has_byte),
		.last     (in_data.last),
		.sts      (sts),
		.cmd      (cmd)
	);

	sha_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (in_data.data_byte),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// A compression only runs over a complete block
	a_round_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round_en |-> (sts.fill == 6'd0))
		else $error("round issued on a partly filled block");

	// Byte intake never overlaps the round unit or the fold
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!((cmd.take_in || cmd.pad_push) && (cmd.round_en || cmd.fold)))
		else $error("byte push during compression");

	// Loading the eighth word returns the block to intake
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_load && (cmd.emit_idx == 3'd7)) |=> in_ready)
		else $error("intake not resumed after the final digest word");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for sha256_hash: byte requests in, digest word requests out.
// Depends on sha_pkg for the request types; every digest is predicted here.
module testbench;
	import sha_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_REQUESTS = 320;
	localparam int MAX_REPORTS = 10;
	localparam logic [7:0] MARK_BYTE = 8'h80;

	localparam logic [31:0] HASH_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Hash state mirror and queue of digest words still owed by the block
	class digest_scoreboard;
		logic [31:0] chain [8];
		logic [7:0]  blk [64];
		logic [60:0] taken;
		out_item_t   words_due [$];
		int          mismatches;
		int          words_checked;

		function new();
			mismatches = 0;
			words_checked = 0;
			foreach (blk[i]) blk[i] = 8'h00;
			start_message();
		endfunction

		function void start_message();
			chain = HASH_IV;
			taken = '0;
		endfunction

		function logic [31:0] ror32(logic [31:0] v, int s);
			logic [63:0] twice;
			twice = {v, v} >> s;
			return twice[31:0];
		endfunction

		// Expand the schedule, run 64 rounds and fold into the chain
		function void compress_block();
			logic [31:0] w [64];
			logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
			for (int t = 0; t < 16; t++) begin
				w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
			end
			for (int t = 16; t < 64; t++) begin
				w[t] = w[t-16] + w[t-7]
					+ (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
					+ (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10));
			end
			a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
			e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
			for (int t = 0; t < 64; t++) begin
				t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
					+ ((e & f) ^ (~e & g)) + ROUND_CONST[t] + w[t];
				t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
					+ ((a & b) ^ (a & c) ^ (b & c));
				h = g; g = f; f = e; e = d + t1;
				d = c; c = b; b = a; a = t1 + t2;
			end
			chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
			chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
		endfunction

		// Absorb one accepted request; on last, pad and queue the digest
		function void note_request(in_item_t req);
			logic [5:0]  pos;
			logic [63:0] bit_len;
			out_item_t   word;
			if (req.has_byte) begin
				pos = taken[5:0];
				blk[pos] = req.data_byte;
				taken = taken + 61'd1;
				if (pos == 6'd63) compress_block();
			end
			if (!req.last) return;
			pos = taken[5:0];
			blk[pos] = MARK_BYTE;
			for (int k = int'(pos) + 1; k < 64; k++) blk[k] = 8'h00;
			// no room for the length: close this block and open a blank one
			if (pos >= 6'd56) begin
				compress_block();
				for (int k = 0; k < 56; k++) blk[k] = 8'h00;
			end
			bit_len = {taken, 3'b000};
			for (int k = 0; k < 8; k++) blk[56 + k] = bit_len[63 - 8*k -: 8];
			compress_block();
			for (int k = 0; k < 8; k++) begin
				word.digest_word = chain[k];
				word.word_index  = 3'(k);
				word.last_word   = (k == 7);
				words_due.push_back(word);
			end
			start_message();
		endfunction

		function void flag_mismatch(string what);
			if (mismatches < MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, what);
			mismatches++;
		endfunction

		// Compare one accepted digest word with the oldest one owed
		function void check_word(out_item_t got);
			out_item_t want;
			if (words_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected word %h index %0d last %0b",
					got.digest_word, got.word_index, got.last_word));
				return;
			end
			want = words_due.pop_front();
			words_checked++;
			if (got !== want) begin
				flag_mismatch($sformatf("expected %h/%0d/%0b, got %h/%0d/%0b",
					want.digest_word, want.word_index, want.last_word,
					got.digest_word, got.word_index, got.last_word));
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	digest_scoreboard sb;
	int  bytes_sent = 0;
	int  messages_done = 0;
	int  longest_msg = 0;
	bit  steady_tx = 1'b0;
	bit  steady_rx = 1'b0;
	int  stall_left = 0;
	int  rx_cycles = 0;
	int  quiet_cycles = 0;

	sha256_hash u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Idle length: mostly short, now and then long
	function automatic int pick_idle();
		int r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(1, 2);
		if (r < 93) return $urandom_range(3, 8);
		return $urandom_range(20, 50);
	endfunction

	function automatic int sender_gap();
		if (steady_tx || $urandom_range(99) < 55) return 0;
		return pick_idle();
	endfunction

	// Offer one request, hold it until taken, then note it
	task automatic send_request(input logic [7:0] b, input bit with_byte, input bit ends);
		in_item_t req;
		int       gap;
		req.data_byte = b;
		req.has_byte  = with_byte;
		req.last      = ends;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		sb.note_request(req);
		if (with_byte) bytes_sent++;
		if (ends) messages_done++;
	endtask

	// Hold the sender until every owed digest word has come out
	task automatic wait_for_digests();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.words_due.size() != 0);
	endtask

	// Check accepted words and choose the next ready level
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_word(out_data);
		rx_cycles++;
		if (rx_cycles % 97 == 0) steady_rx = ($urandom_range(2) == 0);
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!steady_rx && $urandom_range(99) < 30) begin
			stall_left = pick_idle() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Drop the run if no request moves on either side for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		int boundary_len [10];
		int random_sent;
		int len;
		int r;
		bit last_on_byte;
		boundary_len = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
		sb = new();
		random_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// empty message, then let the digest drain fully
		send_request(8'h00, 1'b0, 1'b1);
		wait_for_digests();
		// single byte carried on the last request
		send_request(8'hff, 1'b1, 1'b1);
		// bytes, an ignored request, then last on its own
		send_request(8'h00, 1'b1, 1'b0);
		send_request(8'h5a, 1'b0, 1'b0);
		send_request(8'ha5, 1'b1, 1'b0);
		send_request(8'h00, 1'b0, 1'b1);
		// "abc"
		send_request(8'h61, 1'b1, 1'b0);
		send_request(8'h62, 1'b1, 1'b0);
		send_request(8'h63, 1'b1, 1'b1);
		send_request(8'h80, 1'b1, 1'b0);
		send_request(8'h7f, 1'b1, 1'b0);
		send_request(8'h01, 1'b1, 1'b1);
		longest_msg = 3;

		// random messages, lengths biased to short and block-boundary cases
		while (random_sent < RANDOM_REQUESTS) begin
			steady_tx = ($urandom_range(3) == 0);
			r = $urandom_range(99);
			if (r < 60) len = $urandom_range(0, 12);
			else if (r < 85) len = boundary_len[$urandom_range(0, 9)];
			else len = $urandom_range(13, 130);
			last_on_byte = (len > 0) && ($urandom_range(1) == 1);
			if (len > longest_msg) longest_msg = len;
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(99) < 5) send_request(8'($urandom), 1'b0, 1'b0);
				send_request(8'($urandom), 1'b1, last_on_byte && (i == len - 1));
				random_sent++;
			end
			if (!last_on_byte) begin
				send_request(8'($urandom), 1'b0, 1'b1);
				random_sent++;
			end
			if ($urandom_range(5) == 0) wait_for_digests();
		end

		wait_for_digests();
		repeat (20) @(posedge clk);
		$display("covered %0d messages, %0d bytes, longest %0d bytes, %0d digest words checked",
			messages_done, bytes_sent, longest_msg, sb.words_checked);
		$display("incl. empty, one-byte, padding-overflow lengths, idle requests, both-side stalls");
		if (sb.mismatches == 0 && sb.words_due.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("%0d mismatches, %0d digest words never arrived",
				sb.mismatches, sb.words_due.size());
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
